FILE: rtl/core/ptc_pkg.sv
// ---------------------------------------------------------------------------
// ptc_pkg
// shared constants and arithmetic helpers for the pressure/temperature core
// ---------------------------------------------------------------------------
package ptc_pkg;

	localparam int TF_OFFSET = 128000;
	localparam int P_SCALE   = 3125;
	localparam int P_BASE    = 1048576;
	localparam int SH_ONE    = 47;
	localparam int SH_DIV    = 33;
	localparam int SH_P4     = 35;
	localparam int T_ROUND   = 128;
	localparam int DIV_BITS  = 64;
	localparam int PRESS_MAX = 262143;
	localparam int TEMP_MAX  = 32767;
	localparam int TEMP_MIN  = -32768;

	typedef enum logic [1:0] {
		REG_TEMP_CAL = 2'd0,
		REG_PRESS_A  = 2'd1,
		REG_PRESS_B  = 2'd2,
		REG_PRESS_C  = 2'd3
	} reg_idx_t;

	typedef logic [47:0] cal_word_t;

	function automatic logic [31:0] asr32(input logic [31:0] x, input int n);
		return 32'($signed(x) >>> n);
	endfunction

	function automatic logic [63:0] asr64(input logic [63:0] x, input int n);
		return 64'($signed(x) >>> n);
	endfunction

	// 64-bit wrapping product with a signed 16-bit coefficient
	function automatic logic [63:0] mul64x16(input logic [63:0] a, input logic signed [15:0] c);
		logic signed [63:0] cx;
		cx = 64'(c);
		return 64'($signed(a) * cx);
	endfunction

endpackage

FILE: rtl/core/pressure_temperature_compensation_core.sv
// ---------------------------------------------------------------------------
// pressure_temperature_compensation_core
// pipelined barometer compensation: raw temperature/pressure to centi-degC/Pa
// ---------------------------------------------------------------------------
// input stream s_*: one beat carries a raw temperature and raw pressure pair
// output stream m_*: one beat carries temperature, pressure and a valid flag
// calibration is loaded through cfg_we/cfg_index/cfg_data; user must do it while idle, core does not enforce
// every beat goes through 80 register stages: 10 for the temperature and
// pressure polynomials, 65 for the signed 64-bit divider (sign and magnitude
// entry, then one quotient bit per stage) and 5 for the pressure correction
// terms
// throughput is one beat per cycle when not stalled; the divider stages set the depth
// when m_tready is low with a result waiting, the whole pipeline holds and
// s_tready drops; nothing is lost or repeated
// a zero divisor gives pressure 0 with the valid flag low
// arst_n clears the calibration registers and all stage valid bits
// ---------------------------------------------------------------------------
module pressure_temperature_compensation_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // raw_temperature[19:0], raw_pressure[39:20]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // temperature_centi[15:0], pressure_pa[33:16], pressure_valid[34]
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [47:0] cfg_data
);

	localparam int NDIV = ptc_pkg::DIV_BITS;

	ptc_pkg::cal_word_t cal_t_q, cal_a_q, cal_b_q, cal_c_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_t_q <= '0;
			cal_a_q <= '0;
			cal_b_q <= '0;
			cal_c_q <= '0;
		end else if (cfg_we) begin
			unique case (ptc_pkg::reg_idx_t'(cfg_index))
				ptc_pkg::REG_TEMP_CAL: cal_t_q <= cfg_data;
				ptc_pkg::REG_PRESS_A:  cal_a_q <= cfg_data;
				ptc_pkg::REG_PRESS_B:  cal_b_q <= cfg_data;
				ptc_pkg::REG_PRESS_C:  cal_c_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [15:0] t1, p1;
	logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;

	assign t1 = cal_t_q[15:0];
	assign t2 = $signed(cal_t_q[31:16]);
	assign t3 = $signed(cal_t_q[47:32]);
	assign p1 = cal_a_q[15:0];
	assign p2 = $signed(cal_a_q[31:16]);
	assign p3 = $signed(cal_a_q[47:32]);
	assign p4 = $signed(cal_b_q[15:0]);
	assign p5 = $signed(cal_b_q[31:16]);
	assign p6 = $signed(cal_b_q[47:32]);
	assign p7 = $signed(cal_c_q[15:0]);
	assign p8 = $signed(cal_c_q[31:16]);
	assign p9 = $signed(cal_c_q[47:32]);

	logic ce;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9, vld_s10;
	logic vld_d1, vld_d2, vld_d3, vld_d4, vld_d5;
	logic dv_vld_s [0:NDIV];

	assign ce       = !vld_d5 || m_tready;
	assign s_tready = ce;

	// temperature path
	logic [31:0] a_s1, b_s1, at_s2, bb_s2, v1t_s3, w_s3, tf_s4;
	logic [19:0] adcp_s1, adcp_s2, adcp_s3, adcp_s4, adcp_s5, adcp_s6, adcp_s7, adcp_s8;
	logic [15:0] tc_s5, tc_s6, tc_s7, tc_s8, tc_s9, tc_s10;
	logic signed [33:0] v1_s5;
	logic [31:0] tcw;
	logic [15:0] tc_sat;

	// pressure polynomial
	logic [63:0] sq_s6, m5_s6, m2_s6, x6_s7, x3_s7, m5_s7, m2_s7;
	logic [63:0] v2_s8, v1b_s8, y_s9, t_s9, den_s10, num_s10;

	// divider
	logic [63:0] dv_rem_s [0:NDIV];
	logic [63:0] dv_nq_s  [0:NDIV];
	logic [63:0] dv_den_s [0:NDIV];
	logic        dv_neg_s [0:NDIV];
	logic        dv_nz_s  [0:NDIV];
	logic [15:0] dv_tc_s  [0:NDIV];

	// correction
	logic [63:0] q_w, h_w;
	logic [63:0] p_d1, p_d2, p_d3, hsql_d1, pr8_d1, hsq_d2, d2_d2, d2_d3, d1p_d3, s_d4;
	logic [31:0] hx_d1;
	logic        nz_d1, nz_d2, nz_d3, nz_d4, nz_d5;
	logic [15:0] tc_d1, tc_d2, tc_d3, tc_d4, tc_d5;
	logic [17:0] pres_d5;
	logic [63:0] pp_w, pq_w;
	logic [17:0] pres_w;

	always_comb begin
		tcw = ptc_pkg::asr32(32'(tf_s4 * 32'd5) + 32'(ptc_pkg::T_ROUND), 8);
		if ($signed(tcw) > 32'sd32767)
			tc_sat = 16'(ptc_pkg::TEMP_MAX);
		else if ($signed(tcw) < -32'sd32768)
			tc_sat = 16'(ptc_pkg::TEMP_MIN);
		else
			tc_sat = tcw[15:0];
	end

	assign q_w = dv_neg_s[NDIV] ? 64'(-dv_nq_s[NDIV]) : dv_nq_s[NDIV];
	assign h_w = ptc_pkg::asr64(q_w, 13);

	always_comb begin
		pp_w = ptc_pkg::asr64(s_d4, 8) + (64'(p7) << 4);
		pq_w = ptc_pkg::asr64(pp_w, 8);
		if (pq_w[63])
			pres_w = '0;
		else if (pq_w > 64'(ptc_pkg::PRESS_MAX))
			pres_w = 18'(ptc_pkg::PRESS_MAX);
		else
			pres_w = pq_w[17:0];
		if (!nz_d4)
			pres_w = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			for (int k = 0; k <= NDIV; k++) dv_vld_s[k] <= 1'b0;
			vld_d1  <= 1'b0;
			vld_d2  <= 1'b0;
			vld_d3  <= 1'b0;
			vld_d4  <= 1'b0;
			vld_d5  <= 1'b0;
		end else if (ce) begin
			vld_s1  <= s_tvalid;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			dv_vld_s[0] <= vld_s10;
			for (int k = 0; k < NDIV; k++) dv_vld_s[k+1] <= dv_vld_s[k];
			vld_d1  <= dv_vld_s[NDIV];
			vld_d2  <= vld_d1;
			vld_d3  <= vld_d2;
			vld_d4  <= vld_d3;
			vld_d5  <= vld_d4;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			// s1
			a_s1    <= 32'(s_tdata[19:3]) - {15'b0, t1, 1'b0};
			b_s1    <= 32'(s_tdata[19:4]) - 32'(t1);
			adcp_s1 <= s_tdata[39:20];
			// s2
			at_s2   <= 32'(a_s1 * 32'(t2));
			bb_s2   <= 32'(b_s1 * b_s1);
			adcp_s2 <= adcp_s1;
			// s3
			v1t_s3  <= ptc_pkg::asr32(at_s2, 11);
			w_s3    <= 32'(ptc_pkg::asr32(bb_s2, 12) * 32'(t3));
			adcp_s3 <= adcp_s2;
			// s4
			tf_s4   <= v1t_s3 + ptc_pkg::asr32(w_s3, 14);
			adcp_s4 <= adcp_s3;
			// s5
			tc_s5   <= tc_sat;
			v1_s5   <= 34'($signed(tf_s4)) - 34'(ptc_pkg::TF_OFFSET);
			adcp_s5 <= adcp_s4;
			// s6
			sq_s6   <= 64'(v1_s5 * v1_s5);
			m5_s6   <= 64'(v1_s5 * p5);
			m2_s6   <= 64'(v1_s5 * p2);
			tc_s6   <= tc_s5;
			adcp_s6 <= adcp_s5;
			// s7
			x6_s7   <= ptc_pkg::mul64x16(sq_s6, p6);
			x3_s7   <= ptc_pkg::mul64x16(sq_s6, p3);
			m5_s7   <= m5_s6;
			m2_s7   <= m2_s6;
			tc_s7   <= tc_s6;
			adcp_s7 <= adcp_s6;
			// s8
			v2_s8   <= x6_s7 + (m5_s7 << 17) + (64'(p4) << ptc_pkg::SH_P4);
			v1b_s8  <= ptc_pkg::asr64(x3_s7, 8) + (m2_s7 << 12);
			tc_s8   <= tc_s7;
			adcp_s8 <= adcp_s7;
			// s9
			y_s9    <= (64'd1 << ptc_pkg::SH_ONE) + v1b_s8;
			t_s9    <= ((64'(ptc_pkg::P_BASE) - 64'(adcp_s8)) << 31) - v2_s8;
			tc_s9   <= tc_s8;
			// s10
			den_s10 <= ptc_pkg::asr64(64'(y_s9 * 64'(p1)), ptc_pkg::SH_DIV);
			num_s10 <= 64'(t_s9 * 64'(ptc_pkg::P_SCALE));
			tc_s10  <= tc_s9;
			// divider entry: magnitudes and result sign
			dv_rem_s[0] <= '0;
			dv_nq_s[0]  <= num_s10[63] ? 64'(-num_s10) : num_s10;
			dv_den_s[0] <= den_s10[63] ? 64'(-den_s10) : den_s10;
			dv_neg_s[0] <= num_s10[63] ^ den_s10[63];
			dv_nz_s[0]  <= den_s10 != '0;
			dv_tc_s[0]  <= tc_s10;
			// d1
			p_d1    <= q_w;
			hsql_d1 <= 64'(h_w[31:0]) * 64'(h_w[31:0]);
			hx_d1   <= 32'(h_w[31:0] * h_w[63:32]);
			pr8_d1  <= ptc_pkg::mul64x16(q_w, p8);
			nz_d1   <= dv_nz_s[NDIV];
			tc_d1   <= dv_tc_s[NDIV];
			// d2
			hsq_d2  <= hsql_d1 + {hx_d1[30:0], 33'b0};
			d2_d2   <= ptc_pkg::asr64(pr8_d1, 19);
			p_d2    <= p_d1;
			nz_d2   <= nz_d1;
			tc_d2   <= tc_d1;
			// d3
			d1p_d3  <= ptc_pkg::mul64x16(hsq_d2, p9);
			d2_d3   <= d2_d2;
			p_d3    <= p_d2;
			nz_d3   <= nz_d2;
			tc_d3   <= tc_d2;
			// d4
			s_d4    <= p_d3 + ptc_pkg::asr64(d1p_d3, 25) + d2_d3;
			nz_d4   <= nz_d3;
			tc_d4   <= tc_d3;
			// d5
			pres_d5 <= pres_w;
			nz_d5   <= nz_d4;
			tc_d5   <= tc_d4;
		end
	end

	// one quotient bit per stage, restoring
	for (genvar k = 0; k < NDIV; k++) begin : g_div
		logic [64:0] trial;
		logic        take;

		assign trial = {dv_rem_s[k], dv_nq_s[k][63]};
		assign take  = trial >= {1'b0, dv_den_s[k]};

		always_ff @(posedge clk) begin
			if (ce) begin
				dv_rem_s[k+1] <= take ? 64'(trial - {1'b0, dv_den_s[k]}) : trial[63:0];
				dv_nq_s[k+1]  <= {dv_nq_s[k][62:0], take};
				dv_den_s[k+1] <= dv_den_s[k];
				dv_neg_s[k+1] <= dv_neg_s[k];
				dv_nz_s[k+1]  <= dv_nz_s[k];
				dv_tc_s[k+1]  <= dv_tc_s[k];
			end
		end
	end

	assign m_tvalid = vld_d5;
	assign m_tdata  = {5'b0, nz_d5, pres_d5, tc_d5};

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[34] |-> m_tdata[33:16] == '0)
		else $error("pressure not zero with valid flag low");

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		dv_vld_s[NDIV] && dv_nz_s[NDIV] |-> dv_rem_s[NDIV] < dv_den_s[NDIV])
		else $error("divider remainder not below divisor");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> vld_s1)
		else $error("accepted beat did not enter the pipeline");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!ce |=> $stable(dv_vld_s[NDIV/2]) && $stable(vld_s5))
		else $error("pipeline moved during a stall");

endmodule
